### src/assert_macros.svh
// Assertion helpers; expect signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/lct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lct_pkg;

   localparam int CODE_W          = 24;
   localparam int DEFAULT_ENTRIES = 16;

   localparam logic [CODE_W-1:0] EMPTY_CODE = 24'hFF_FFFF;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;

   localparam logic [1:0] STATUS_STORED  = 2'd0;
   localparam logic [1:0] STATUS_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CODE_W-1:0] code;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
   } rsp_type;

endpackage
`default_nettype wire

### src/learned_code_table_top.sv
// channel  direction  handshake             payload
// req_     in         req_valid/req_stall   lct_pkg::req_type {kind, code}
// rsp_     out        rsp_valid/rsp_stall   lct_pkg::rsp_type {status, found}
//
// Add and lookup scan the slot memory one entry per cycle, then pass through a drain
// state before response valid; erase and unused kinds respond in the cycle after accept.
// One request in flight; req_stall stays high until the response is taken.
// Synchronous reset marks every slot empty (valid bits cleared), no sweep.
// A stalled response holds in its output register.
`timescale 1ns / 1ps
`default_nettype none
module learned_code_table_top #(
   parameter int ENTRIES = lct_pkg::DEFAULT_ENTRIES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire lct_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lct_pkg::rsp_type rsp_data
);
   import lct_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              cmp_on_ff, cmp_on_in;
   logic              dup_ff, dup_in;
   logic              have_ff, have_in;
   logic [IDX_W-1:0]  empty_at_ff, empty_at_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [ENTRIES-1:0] slot_vld_ff, slot_vld_in;
   logic              rd_vld_ff;
   logic [CODE_W-1:0] rd_code_ff;

   logic [CODE_W-1:0] code_mem [ENTRIES];

   logic              mem_we;
   logic [IDX_W-1:0]  wr_idx;
   logic              clr_all;
   logic [CODE_W-1:0] slot_val;
   logic              hit, emp;
   logic              dup_now, have_now;
   logic [IDX_W-1:0]  at_now;

   assign slot_val = rd_vld_ff ? rd_code_ff : EMPTY_CODE;
   assign hit      = cmp_on_ff && (slot_val == code_ff);
   assign emp      = cmp_on_ff && (slot_val == EMPTY_CODE);
   assign dup_now  = dup_ff | hit;
   assign have_now = have_ff | emp;
   assign at_now   = (!have_ff && emp) ? cmp_idx_ff : empty_at_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_on_in    = cmp_on_ff;
      dup_in       = dup_ff;
      have_in      = have_ff;
      empty_at_in  = empty_at_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      wr_idx       = at_now;
      clr_all      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in     = req_data.kind;
               code_in     = req_data.code;
               rd_idx_in   = '0;
               cmp_on_in   = 1'b0;
               dup_in      = 1'b0;
               have_in     = 1'b0;
               empty_at_in = '0;
               rsp_data_in = '0;
               case (req_data.kind)
                  KIND_ADD, KIND_LOOKUP: begin
                     state_in = S_SCAN;
                  end
                  KIND_ERASE: begin
                     clr_all      = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            dup_in      = dup_now;
            have_in     = have_now;
            empty_at_in = at_now;
            cmp_on_in   = 1'b1;
            cmp_idx_in  = rd_idx_ff;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            cmp_on_in    = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
            rsp_data_in  = '0;
            if (kind_ff == KIND_ADD) begin
               if (dup_now) begin
                  rsp_data_in.status = STATUS_PRESENT;
               end else if (!have_now) begin
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  mem_we             = 1'b1;
                  rsp_data_in.status = STATUS_STORED;
               end
            end else begin
               rsp_data_in.found = dup_now;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      slot_vld_in = slot_vld_ff;
      if (clr_all) begin
         slot_vld_in = '0;
      end
      if (mem_we) begin
         slot_vld_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_on_ff    <= cmp_on_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_vld_ff  <= slot_vld_in;
      end
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      dup_ff      <= dup_in;
      have_ff     <= have_in;
      empty_at_ff <= empty_at_in;
      rsp_data_ff <= rsp_data_in;
      rd_vld_ff   <= slot_vld_ff[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         code_mem[wr_idx] <= code_ff;
      end
      rd_code_ff <= code_mem[rd_idx_ff];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "assert_macros.svh"

   `ASSERT_NOW(a_no_accept_while_rsp, req_valid && !req_stall, !rsp_valid)
   `ASSERT_NOW(a_found_only_lookup, rsp_valid && rsp_data.found, kind_ff == KIND_LOOKUP)
   `ASSERT_NOW(a_status_only_add, rsp_valid && (rsp_data.status != STATUS_STORED), kind_ff == KIND_ADD)
   `ASSERT_NEXT(a_erase_clears, req_valid && !req_stall && (req_data.kind == KIND_ERASE), slot_vld_ff == '0)

endmodule
`default_nettype wire
